// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked, disabled during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property check, prop may hold an implication
`define DAB_ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// plain invariant on every clock edge
`define DAB_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    `DAB_ASSERT_PROP(label, clk, rst_n, (expr), msg)

`endif

// ----- hdl/dab_pkg.sv -----
// ----------------------------------------------------------------------------
// dab_pkg
// types, constants and beep patterns of the door open alarm beeper
// ----------------------------------------------------------------------------
package dab_pkg;

    localparam int unsigned SETUP_TICKS = 500;
    localparam int unsigned SETUP_W     = 9;
    localparam int unsigned CNT_W       = 16;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned TONE_W      = 10;
    localparam int unsigned PAT_CNT_W   = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_WARN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE = 2'd2;

    localparam logic [CNT_W-1:0] WARN_RESET    = 16'd1800;
    localparam logic [CNT_W-1:0] ALARM_RESET   = 16'd2400;
    localparam logic [CNT_W-1:0] SILENCE_RESET = 16'd6000;
    localparam logic [CNT_W-1:0] CNT_MAX       = 16'hffff;

    typedef struct packed {
        logic [PAT_CNT_W-1:0] inner_on;
        logic [PAT_CNT_W-1:0] inner_period;
        logic [PAT_CNT_W-1:0] outer_on;
        logic [PAT_CNT_W-1:0] outer_period;
        logic [TONE_W-1:0]    tone;
        logic                 one_shot;
    } t_pattern;

    typedef struct packed {
        logic     load;
        t_pattern pattern;
    } t_load;

    localparam t_pattern PAT_POWERUP = '{8'd1, 8'd4, 8'd1,  8'd10, 10'd150, 1'b1};
    localparam t_pattern PAT_TEST    = '{8'd1, 8'd2, 8'd11, 8'd10, 10'd800, 1'b0};
    localparam t_pattern PAT_OFF     = '{8'd0, 8'd0, 8'd0,  8'd0,  10'd0,   1'b0};
    localparam t_pattern PAT_READY   = '{8'd5, 8'd4, 8'd3,  8'd10, 10'd150, 1'b1};
    localparam t_pattern PAT_MUTE    = '{8'd5, 8'd4, 8'd2,  8'd10, 10'd700, 1'b1};
    localparam t_pattern PAT_CLOSE   = '{8'd1, 8'd2, 8'd2,  8'd10, 10'd150, 1'b1};
    localparam t_pattern PAT_WARN    = '{8'd1, 8'd4, 8'd3,  8'd15, 10'd600, 1'b0};
    localparam t_pattern PAT_ALARM   = '{8'd2, 8'd4, 8'd10, 8'd20, 10'd150, 1'b0};

endpackage

// ----- hdl/dab_in_if.sv -----
// ----------------------------------------------------------------------------
// dab_in_if
// tick channel carrying door sensor and mute button levels
// ----------------------------------------------------------------------------
interface dab_in_if;
    logic valid;
    logic ready;
    logic door_level;
    logic mute_level;

    modport source (output valid, output door_level, output mute_level, input ready);
    modport sink   (input valid, input door_level, input mute_level, output ready);
endinterface

// ----- hdl/dab_out_if.sv -----
// ----------------------------------------------------------------------------
// dab_out_if
// result channel carrying the tone period of one tick
// ----------------------------------------------------------------------------
interface dab_out_if;
    logic       valid;
    logic       ready;
    logic [9:0] tone_period;
    logic       tone_active;

    modport source (output valid, output tone_period, output tone_active, input ready);
    modport sink   (input valid, input tone_period, input tone_active, output ready);
endinterface

// ----- hdl/dab_ctrl.sv -----
// ----------------------------------------------------------------------------
// dab_ctrl
// setup window, door-open counter, thresholds and pattern selection
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dab_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic                           i_door,
    input  logic                           i_mute,
    input  logic                           i_cfg_we,
    input  logic [dab_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dab_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output dab_pkg::t_load                 o_load
);
    import dab_pkg::*;

    logic [CNT_W-1:0]   r_warn, r_alarm, r_silence;
    logic [SETUP_W-1:0] r_setup, n_setup;
    logic               r_last_door;
    logic [CNT_W-1:0]   r_open_cnt, n_open_cnt;
    logic               r_mute_flag, n_mute_flag;
    t_load              n_load;

    always_comb begin
        n_setup     = r_setup;
        n_open_cnt  = r_open_cnt;
        n_mute_flag = r_mute_flag;
        n_load      = '{load: 1'b0, pattern: PAT_OFF};
        if (r_setup != '0) begin
            if (i_door && !r_last_door) begin
                n_load = '{load: 1'b1, pattern: PAT_TEST};
            end else if (!i_door && r_last_door) begin
                n_load = '{load: 1'b1, pattern: PAT_OFF};
            end
            if (r_setup == SETUP_W'(1)) begin
                n_load = '{load: 1'b1, pattern: PAT_READY};
            end
            n_setup = r_setup - SETUP_W'(1);
        end else begin
            if (!i_door) begin
                if (r_open_cnt != CNT_MAX) begin
                    n_open_cnt = r_open_cnt + CNT_W'(1);
                end
                if (!i_mute) begin
                    n_mute_flag = 1'b1;
                    n_load      = '{load: 1'b1, pattern: PAT_MUTE};
                end
            end else begin
                if (r_open_cnt > r_warn || r_mute_flag) begin
                    n_load = '{load: 1'b1, pattern: PAT_CLOSE};
                end
                n_open_cnt  = '0;
                n_mute_flag = 1'b0;
            end
            if (n_open_cnt == r_warn && !n_mute_flag) begin
                n_load = '{load: 1'b1, pattern: PAT_WARN};
            end
            if (n_open_cnt == r_alarm && !n_mute_flag) begin
                n_load = '{load: 1'b1, pattern: PAT_ALARM};
            end
            if (n_open_cnt == r_silence) begin
                n_load = '{load: 1'b1, pattern: PAT_OFF};
            end
        end
    end

    assign o_load = n_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warn    <= WARN_RESET;
            r_alarm   <= ALARM_RESET;
            r_silence <= SILENCE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WARN:    r_warn    <= i_cfg_data;
                CFG_ALARM:   r_alarm   <= i_cfg_data;
                CFG_SILENCE: r_silence <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setup     <= SETUP_W'(SETUP_TICKS);
            r_last_door <= 1'b0;
            r_open_cnt  <= '0;
            r_mute_flag <= 1'b0;
        end else if (i_step) begin
            r_setup     <= n_setup;
            r_last_door <= i_door;
            r_open_cnt  <= n_open_cnt;
            r_mute_flag <= n_mute_flag;
        end
    end

    // open counter and mute only run after setup
    `DAB_ASSERT_ALWAYS(a_cnt_after_setup, i_clk, i_rst_n, (r_open_cnt == '0) || (r_setup == '0), "open count moved during setup")
    `DAB_ASSERT_ALWAYS(a_mute_after_setup, i_clk, i_rst_n, !r_mute_flag || (r_setup == '0), "mute flag set during setup")

endmodule

// ----- hdl/dab_pattern.sv -----
// ----------------------------------------------------------------------------
// dab_pattern
// two-level beep pattern generator with one-shot mode
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dab_pattern (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  dab_pkg::t_load             i_load,
    output logic [dab_pkg::TONE_W-1:0] o_tone
);
    import dab_pkg::*;

    t_pattern             r_pat, n_pat;
    logic [PAT_CNT_W-1:0] r_inner_cnt, n_inner_cnt;
    logic [PAT_CNT_W-1:0] r_outer_cnt, n_outer_cnt;
    t_pattern             cur_pat;
    logic [PAT_CNT_W-1:0] cur_inner, cur_outer;

    always_comb begin
        cur_pat   = i_load.load ? i_load.pattern : r_pat;
        cur_inner = i_load.load ? '0 : r_inner_cnt;
        cur_outer = i_load.load ? '0 : r_outer_cnt;

        if (cur_inner < cur_pat.inner_on && cur_outer < cur_pat.outer_on) begin
            o_tone = cur_pat.tone;
        end else begin
            o_tone = '0;
        end

        n_pat       = cur_pat;
        n_inner_cnt = cur_inner;
        n_outer_cnt = cur_outer;
        if (cur_inner < cur_pat.inner_period) begin
            n_inner_cnt = cur_inner + PAT_CNT_W'(1);
        end else begin
            n_inner_cnt = '0;
            if (cur_outer < cur_pat.outer_period) begin
                n_outer_cnt = cur_outer + PAT_CNT_W'(1);
            end else begin
                n_outer_cnt = '0;
                if (cur_pat.one_shot) begin
                    n_pat.outer_on = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat       <= PAT_POWERUP;
            r_inner_cnt <= '0;
            r_outer_cnt <= '0;
        end else if (i_step) begin
            r_pat       <= n_pat;
            r_inner_cnt <= n_inner_cnt;
            r_outer_cnt <= n_outer_cnt;
        end
    end

    // counters never run past their periods
    `DAB_ASSERT_ALWAYS(a_inner_bound, i_clk, i_rst_n, r_inner_cnt <= r_pat.inner_period, "inner count past period")
    `DAB_ASSERT_ALWAYS(a_outer_bound, i_clk, i_rst_n, r_outer_cnt <= r_pat.outer_period, "outer count past period")

endmodule

// ----- hdl/door_open_alarm_beeper.sv -----
// ----------------------------------------------------------------------------
// door_open_alarm_beeper
// path: a tick transfer is captured in the input register, and its tone result is held in the result register
// throughput: one tick per cycle while the result side does not stall, set by the control and pattern step
// an input register and a result register let both sides stall independently
// reset: 500 setup ticks with a power-up chirp pattern, default thresholds loaded
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module door_open_alarm_beeper (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    dab_in_if.sink                         i_in,
    dab_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [dab_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dab_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dab_pkg::*;

    logic              r_in_valid;
    logic              r_in_door;
    logic              r_in_mute;
    logic              r_out_valid;
    logic [TONE_W-1:0] r_out_tone;
    logic              r_out_active;
    logic              step;
    t_load             load;
    logic [TONE_W-1:0] tone;

    assign step       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_door <= i_in.door_level;
            r_in_mute <= i_in.mute_level;
        end
    end

    dab_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_door     (r_in_door),
        .i_mute     (r_in_mute),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_load     (load)
    );

    dab_pattern u_pattern (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_load  (load),
        .o_tone  (tone)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_tone   <= tone;
            r_out_active <= (tone != '0);
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.tone_period = r_out_tone;
    assign o_out.tone_active = r_out_active;

    // a held tick waits in the input register until the result side frees
    `DAB_ASSERT_PROP(a_in_held, i_clk, i_rst_n, (r_in_valid && !step) |=> r_in_valid, "held tick dropped")
    `DAB_ASSERT_PROP(a_step_fills_out, i_clk, i_rst_n, step |=> r_out_valid, "step without result")

endmodule

// ----- test/tb_door_open_alarm_beeper.sv -----
// ----------------------------------------------------------------------------
// tb_door_open_alarm_beeper
// self-checking bench for the door open alarm beeper: a scoreboard class
// predicts the tone of every tick transfer and checks each result transfer
// in order; stimulus covers the setup window, threshold crossings, mute,
// closing chirps and several threshold settings, with random idle gaps on
// the tick side and random stalls on the result side
// ----------------------------------------------------------------------------

class tone_scoreboard;
    logic [15:0]       warn_at;
    logic [15:0]       alarm_at;
    logic [15:0]       silence_at;
    logic [8:0]        setup_remaining;
    logic              prev_door;
    logic [15:0]       open_ticks;
    logic              muted;
    dab_pkg::t_pattern beep;
    logic [7:0]        inner_pos;
    logic [7:0]        outer_pos;
    logic [9:0]        pending_tones[$];
    int                errors;

    function new();
        warn_at         = 16'd1800;
        alarm_at        = 16'd2400;
        silence_at      = 16'd6000;
        setup_remaining = 9'(dab_pkg::SETUP_TICKS);
        prev_door       = 1'b0;
        open_ticks      = 16'd0;
        muted           = 1'b0;
        errors          = 0;
        start_beep(8'd1, 8'd4, 8'd1, 8'd10, 10'd150, 1'b1);
    endfunction

    function void start_beep(input logic [7:0] ion, input logic [7:0] iper,
                             input logic [7:0] oon, input logic [7:0] oper,
                             input logic [9:0] tone, input logic once);
        beep.inner_on     = ion;
        beep.inner_period = iper;
        beep.outer_on     = oon;
        beep.outer_period = oper;
        beep.tone         = tone;
        beep.one_shot     = once;
        inner_pos         = 8'd0;
        outer_pos         = 8'd0;
    endfunction

    function void set_threshold(input logic [dab_pkg::CFG_IDX_W-1:0] idx,
                                input logic [dab_pkg::CFG_DATA_W-1:0] value);
        case (idx)
            dab_pkg::CFG_WARN:    warn_at    = value;
            dab_pkg::CFG_ALARM:   alarm_at   = value;
            dab_pkg::CFG_SILENCE: silence_at = value;
            default: ;
        endcase
    endfunction

    function void note_tick(input logic door, input logic mute);
        logic [9:0] tone;
        if (setup_remaining != 9'd0) begin
            if (door && !prev_door)
                start_beep(8'd1, 8'd2, 8'd11, 8'd10, 10'd800, 1'b0);
            else if (!door && prev_door)
                start_beep(8'd0, 8'd0, 8'd0, 8'd0, 10'd0, 1'b0);
            if (setup_remaining == 9'd1)
                start_beep(8'd5, 8'd4, 8'd3, 8'd10, 10'd150, 1'b1);
            setup_remaining = setup_remaining - 9'd1;
        end else begin
            if (!door) begin
                if (open_ticks != 16'hffff)
                    open_ticks = open_ticks + 16'd1;
                if (!mute) begin
                    muted = 1'b1;
                    start_beep(8'd5, 8'd4, 8'd2, 8'd10, 10'd700, 1'b1);
                end
            end else begin
                if (open_ticks > warn_at || muted)
                    start_beep(8'd1, 8'd2, 8'd2, 8'd10, 10'd150, 1'b1);
                open_ticks = 16'd0;
                muted      = 1'b0;
            end
            if (open_ticks == warn_at && !muted)
                start_beep(8'd1, 8'd4, 8'd3, 8'd15, 10'd600, 1'b0);
            if (open_ticks == alarm_at && !muted)
                start_beep(8'd2, 8'd4, 8'd10, 8'd20, 10'd150, 1'b0);
            if (open_ticks == silence_at)
                start_beep(8'd0, 8'd0, 8'd0, 8'd0, 10'd0, 1'b0);
        end
        prev_door = door;

        if (inner_pos < beep.inner_on && outer_pos < beep.outer_on)
            tone = beep.tone;
        else
            tone = 10'd0;

        if (inner_pos < beep.inner_period) begin
            inner_pos = inner_pos + 8'd1;
        end else begin
            inner_pos = 8'd0;
            if (outer_pos < beep.outer_period) begin
                outer_pos = outer_pos + 8'd1;
            end else begin
                outer_pos = 8'd0;
                if (beep.one_shot)
                    beep.outer_on = 8'd0;
            end
        end
        pending_tones.push_back(tone);
    endfunction

    function void check_tone(input logic [9:0] period, input logic active);
        logic [9:0] want;
        if (pending_tones.size() == 0) begin
            $error("tone_period: result with no tick pending, actual %0d", period);
            errors++;
            return;
        end
        want = pending_tones.pop_front();
        if (period !== want) begin
            $error("tone_period: expected %0d, actual %0d", want, period);
            errors++;
        end
        if (active !== (want != 10'd0)) begin
            $error("tone_active: expected %0d, actual %0d", want != 10'd0, active);
            errors++;
        end
    endfunction
endclass

module tb_door_open_alarm_beeper;

    localparam logic [dab_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we;
    logic [dab_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [dab_pkg::CFG_DATA_W-1:0] i_cfg_data;

    dab_in_if  tick_ch ();
    dab_out_if tone_ch ();

    tone_scoreboard sb;
    bit             gaps_on = 1'b1;
    int             stall_left = 0;
    int unsigned    cycles = 0;

    door_open_alarm_beeper uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (tick_ch),
        .o_out      (tone_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic int idle_len();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (tone_ch.valid && tone_ch.ready)
                sb.check_tone(tone_ch.tone_period, tone_ch.tone_active);
            if (tick_ch.valid && tick_ch.ready)
                sb.note_tick(tick_ch.door_level, tick_ch.mute_level);
        end
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** door_open_alarm_beeper: FAILED **");
            $finish;
        end
    end

    // result side stalls
    always @(negedge i_clk) begin
        if (stall_left == 0)
            stall_left = idle_len();
        if (stall_left > 0) begin
            tone_ch.ready <= 1'b0;
            stall_left--;
        end else begin
            tone_ch.ready <= 1'b1;
        end
    end

    task automatic send_tick(input logic door, input logic mute);
        int gap;
        gap = idle_len();
        repeat (gap) begin
            tick_ch.valid      <= 1'b0;
            tick_ch.door_level <= 1'($urandom_range(0, 1));
            tick_ch.mute_level <= 1'($urandom_range(0, 1));
            @(negedge i_clk);
        end
        tick_ch.valid      <= 1'b1;
        tick_ch.door_level <= door;
        tick_ch.mute_level <= mute;
        do @(posedge i_clk); while (!tick_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        tick_ch.valid <= 1'b0;
        while (sb.pending_tones.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic put_reg(input logic [dab_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dab_pkg::CFG_DATA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        sb.set_threshold(idx, value);
    endtask

    task automatic program_thresholds(input logic [15:0] warn, input logic [15:0] alarm,
                                      input logic [15:0] silence);
        put_reg(dab_pkg::CFG_WARN, warn);
        put_reg(CFG_SPARE, 16'($urandom));
        put_reg(dab_pkg::CFG_ALARM, alarm);
        put_reg(dab_pkg::CFG_SILENCE, silence);
        i_cfg_we <= 1'b0;
    endtask

    // open/close sequences sized to the current thresholds, some with mute presses
    task automatic run_door_cycles(input int ticks);
        int sent;
        int cap;
        int style;
        int open_len;
        int shut_len;
        int press_at;
        int press_len;
        cap = int'(sb.warn_at);
        if (int'(sb.alarm_at) > cap)
            cap = int'(sb.alarm_at);
        if (int'(sb.silence_at) > cap)
            cap = int'(sb.silence_at);
        cap = (cap > 56) ? 60 : cap + 4;
        sent = 0;
        while (sent < ticks) begin
            gaps_on   = ($urandom_range(0, 99) < 85);
            style     = $urandom_range(0, 99);
            open_len  = $urandom_range(0, cap);
            press_at  = (style < 30) ? $urandom_range(0, open_len) : open_len + 1;
            press_len = $urandom_range(1, 3);
            shut_len  = $urandom_range(1, 40);
            for (int k = 0; k < open_len; k++) begin
                if (style >= 90)
                    send_tick(1'b0, 1'($urandom_range(0, 1)));
                else
                    send_tick(1'b0, !(k >= press_at && k < press_at + press_len));
            end
            for (int k = 0; k < shut_len; k++) begin
                if (style >= 90)
                    send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                else
                    send_tick(1'b1, $urandom_range(0, 9) != 0);
            end
            sent += open_len + shut_len;
        end
    endtask

    initial begin
        logic door;
        tick_ch.valid      = 1'b0;
        tick_ch.door_level = 1'b0;
        tick_ch.mute_level = 1'b1;
        tone_ch.ready      = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = dab_pkg::CFG_WARN;
        i_cfg_data         = '0;
        sb = new();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // setup window: closed door on the first tick is a closing edge
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        repeat (14) send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        door = 1'b1;
        for (int t = 20; t < int'(dab_pkg::SETUP_TICKS); t++) begin
            if (t % 50 == 0)
                gaps_on = ($urandom_range(0, 9) != 0);
            if ($urandom_range(0, 9) == 0)
                door = ~door;
            send_tick(door, 1'($urandom_range(0, 1)));
        end

        // end-of-setup chirp, then door cycles at the default thresholds
        gaps_on = 1'b1;
        repeat (60) send_tick(1'b1, 1'b1);
        run_door_cycles(100);

        wait_drained();
        program_thresholds(16'd3, 16'd8, 16'd15);
        run_door_cycles(200);

        wait_drained();
        program_thresholds(16'd0, 16'd0, 16'd0);
        run_door_cycles(120);

        repeat (4) begin
            wait_drained();
            program_thresholds(16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)),
                               16'($urandom_range(0, 40)));
            run_door_cycles(150);
        end

        wait_drained();
        program_thresholds(dab_pkg::CNT_MAX, dab_pkg::CNT_MAX, dab_pkg::CNT_MAX);
        run_door_cycles(70);

        wait_drained();
        if (sb.errors == 0)
            $display("** door_open_alarm_beeper: PASSED **");
        else
            $display("** door_open_alarm_beeper: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/dab_pkg.sv
hdl/dab_in_if.sv
hdl/dab_out_if.sv
hdl/dab_ctrl.sv
hdl/dab_pattern.sv
hdl/door_open_alarm_beeper.sv
test/tb_door_open_alarm_beeper.sv
